[src/pblr_pkg.sv]
// Shared constants, types and elaboration-time tables for the progress bar LED renderer.
// Used by every module in src but pblr_checker; depends on nothing.
package pblr_pkg;

    localparam int MAX_LEDS    = 64;
    localparam int PULSE_STEPS = 256;
    localparam int LED_IDX_W   = $clog2(MAX_LEDS);
    localparam int LED_CNT_W   = $clog2(MAX_LEDS + 1);
    localparam int PULSE_IDX_W = $clog2(PULSE_STEPS);
    localparam int LEVEL_W     = 17;
    localparam int PCT_MAX     = 100;
    localparam int PCT_W       = 7;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam logic [LEVEL_W-1:0] ONE_Q16     = 17'd65536;
    localparam logic [LEVEL_W-1:0] DONE_LEVEL  = 17'd65209;
    localparam logic [LEVEL_W-1:0] FLOOR_LEVEL = 17'd9830;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BAR_COLOR    = 2'd0;
    localparam logic [1:0] REG_FINISH_COLOR = 2'd1;
    localparam logic [1:0] REG_GLIDE_ALPHA  = 2'd2;
    localparam logic [1:0] REG_LED_COUNT    = 2'd3;

    localparam logic [23:0]          BAR_COLOR_RST    = 24'h00a0ff;
    localparam logic [23:0]          FINISH_COLOR_RST = 24'h00ff40;
    localparam logic [LEVEL_W-1:0]   GLIDE_ALPHA_RST  = 17'd5190;
    localparam logic [LED_CNT_W-1:0] LED_COUNT_RST    = LED_CNT_W'(MAX_LEDS);

    typedef struct packed {
        logic                  done;
        logic [23:0]           color;
        logic [7:0]            pulse_lv;
        logic [LED_CNT_W-1:0]  head;
        logic [15:0]           frac;
        logic [LED_IDX_W-1:0]  last_idx;
    } frame_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // integer Taylor series for sin(x), x in Q30
    function automatic logic [31:0] sine_mag_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] t;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        for (int n = 1; n <= 6; n++)
        begin
            t = (term * x2) >> 30;
            case (n)
                1: term = t / 64'd6;
                2: term = t / 64'd20;
                3: term = t / 64'd42;
                4: term = t / 64'd72;
                5: term = t / 64'd110;
                default: term = t / 64'd156;
            endcase
            if (n % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum > Q30_ONE)
            sum = Q30_ONE;
        return sum[31:0];
    endfunction

    function automatic logic [PULSE_STEPS*8-1:0] build_pulse_table();
        logic [PULSE_STEPS*8-1:0] tab;
        logic [63:0] turn;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] m;
        logic [1:0]  quad;
        tab = '0;
        for (int k = 0; k < PULSE_STEPS; k++)
        begin
            turn = (64'(k) << 32) / PULSE_STEPS;
            quad = turn[31:30];
            r    = turn & (Q30_ONE - 64'd1);
            if (quad[0])
                r = Q30_ONE - r;
            x = (r * HALF_PI_Q30) >> 30;
            m = (64'd102 * 64'(sine_mag_q30(x)) + 64'd536870912) >> 30;
            if (quad[1])
                tab[k*8 +: 8] = 8'(64'd153 - m);
            else
                tab[k*8 +: 8] = 8'(64'd153 + m);
        end
        return tab;
    endfunction

    // round(p * 65536 / 100) for p = 0..100
    function automatic logic [(PCT_MAX+1)*LEVEL_W-1:0] build_percent_table();
        logic [(PCT_MAX+1)*LEVEL_W-1:0] tab;
        tab = '0;
        for (int p = 0; p <= PCT_MAX; p++)
            tab[p*LEVEL_W +: LEVEL_W] = LEVEL_W'((p * 65536 + 50) / 100);
        return tab;
    endfunction

    localparam logic [PULSE_STEPS*8-1:0]         PULSE_TABLE   = build_pulse_table();
    localparam logic [(PCT_MAX+1)*LEVEL_W-1:0]   PERCENT_TABLE = build_percent_table();

endpackage

[src/progress_bar_led_renderer.sv]
// Top level of the progress bar LED renderer: register file, front end, queue, back end.
// Depends on pblr_pkg, pblr_front, pblr_queue, pblr_back.
//
// Renders a download progress bar onto an LED strip of up to 64 LEDs. Each input
// item is a frame request (percent, active flag, pulse phase) or, with tuser[0]
// set, a reseed that loads both target and shown levels from percent and emits
// nothing. A frame item passes through the front-end steps in order (accept,
// target, glide multiply, update, descriptor) and then yields one pixel item per
// LED (led_count clamped to 1..64), one per cycle while m_tready stays high,
// from the back end's output register, which loads each frame's descriptor
// between frames. A two-entry descriptor queue lets the front end take the next
// item while pixels stream.
// Registers (APB, byte address 4*i): 0 bar_color, 1 finish_color, 2 glide_alpha,
// 3 led_count; write them only while the block is idle.
module progress_bar_led_renderer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // percent[6:0], pulse_phase[14:7]
    input  logic [1:0]                    s_tuser,   // reseed[0], download_active[1]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata,   // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
    output logic                          m_tlast,   // last_pixel
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pblr_pkg::ADDR_W-1:0]   paddr,
    input  logic [pblr_pkg::DATA_W-1:0]   pwdata,
    output logic [pblr_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [23:0]                     bar_color_reg;
    logic [23:0]                     finish_color_reg;
    logic [pblr_pkg::LEVEL_W-1:0]    glide_alpha_reg;
    logic [pblr_pkg::LED_CNT_W-1:0]  led_count_reg;
    logic                            wr_en;

    pblr_pkg::q_stat_t      q_stat;
    pblr_pkg::frame_desc_t  push_desc;
    pblr_pkg::frame_desc_t  pop_desc;
    logic                   push;
    logic                   pop;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            pblr_pkg::REG_BAR_COLOR:    prdata = {8'd0, bar_color_reg};
            pblr_pkg::REG_FINISH_COLOR: prdata = {8'd0, finish_color_reg};
            pblr_pkg::REG_GLIDE_ALPHA:  prdata = {15'd0, glide_alpha_reg};
            pblr_pkg::REG_LED_COUNT:    prdata = {25'd0, led_count_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bar_color_reg    <= pblr_pkg::BAR_COLOR_RST;
            finish_color_reg <= pblr_pkg::FINISH_COLOR_RST;
            glide_alpha_reg  <= pblr_pkg::GLIDE_ALPHA_RST;
            led_count_reg    <= pblr_pkg::LED_COUNT_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                pblr_pkg::REG_BAR_COLOR:    bar_color_reg    <= pwdata[23:0];
                pblr_pkg::REG_FINISH_COLOR: finish_color_reg <= pwdata[23:0];
                pblr_pkg::REG_GLIDE_ALPHA:  glide_alpha_reg  <= pwdata[pblr_pkg::LEVEL_W-1:0];
                pblr_pkg::REG_LED_COUNT:    led_count_reg    <= pwdata[pblr_pkg::LED_CNT_W-1:0];
                default:                    ;
            endcase
        end
    end

    pblr_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .bar_color    (bar_color_reg),
        .finish_color (finish_color_reg),
        .glide_alpha  (glide_alpha_reg),
        .led_count    (led_count_reg),
        .q_stat       (q_stat),
        .push         (push),
        .push_desc    (push_desc)
    );

    pblr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .pop_desc  (pop_desc),
        .q_stat    (q_stat)
    );

    pblr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .pop_desc (pop_desc),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

[src/pblr_front.sv]
// Front end: accepts input items, handles reseed, updates target and shown levels,
// and builds one frame descriptor per frame item. Depends on pblr_pkg.
module pblr_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // percent[6:0], pulse_phase[14:7]
    input  logic [1:0]                      s_tuser,   // reseed[0], download_active[1]
    input  logic [23:0]                     bar_color,
    input  logic [23:0]                     finish_color,
    input  logic [pblr_pkg::LEVEL_W-1:0]    glide_alpha,
    input  logic [pblr_pkg::LED_CNT_W-1:0]  led_count,
    input  pblr_pkg::q_stat_t               q_stat,
    output logic                            push,
    output pblr_pkg::frame_desc_t           push_desc
);

    typedef enum logic [2:0] {F_IDLE, F_TARGET, F_MUL, F_APPLY, F_PUSH} fstate_t;

    fstate_t                         state_reg;
    logic [pblr_pkg::LEVEL_W-1:0]    target_reg;
    logic [pblr_pkg::LEVEL_W-1:0]    shown_reg;
    logic [pblr_pkg::LEVEL_W-1:0]    lvl_reg;
    logic                            active_reg;
    logic [7:0]                      phase_reg;
    logic                            up_reg;
    logic [2*pblr_pkg::LEVEL_W-1:0]  prod_reg;

    logic [pblr_pkg::PCT_W-1:0]      pct_c;
    logic [pblr_pkg::LEVEL_W-1:0]    lvl_in;
    logic [pblr_pkg::LEVEL_W-1:0]    alpha_c;
    logic [pblr_pkg::LEVEL_W-1:0]    diff;
    logic [2*pblr_pkg::LEVEL_W:0]    step_sum;
    logic [pblr_pkg::LEVEL_W-1:0]    step;
    logic [pblr_pkg::LED_CNT_W-1:0]  n_c;
    logic [pblr_pkg::LEVEL_W+pblr_pkg::LED_CNT_W-1:0] pos;
    logic [31:0]                     pidx_wide;
    logic [pblr_pkg::PULSE_IDX_W-1:0] pidx;
    logic                            done;

    assign s_tready = (state_reg == F_IDLE);

    always_comb
    begin
        pct_c = (s_tdata[6:0] > 7'(pblr_pkg::PCT_MAX)) ? 7'(pblr_pkg::PCT_MAX) : s_tdata[6:0];
        lvl_in = pblr_pkg::PERCENT_TABLE[pct_c*pblr_pkg::LEVEL_W +: pblr_pkg::LEVEL_W];

        alpha_c = (glide_alpha > pblr_pkg::ONE_Q16) ? pblr_pkg::ONE_Q16 : glide_alpha;
        diff    = (target_reg >= shown_reg) ? (target_reg - shown_reg) : (shown_reg - target_reg);
        step_sum = {1'b0, prod_reg} + 35'd32768;
        step     = step_sum[32:16];

        if (led_count == '0)
            n_c = 7'd1;
        else if (led_count > pblr_pkg::LED_CNT_W'(pblr_pkg::MAX_LEDS))
            n_c = pblr_pkg::LED_CNT_W'(pblr_pkg::MAX_LEDS);
        else
            n_c = led_count;

        pos  = shown_reg * n_c;
        done = (shown_reg >= pblr_pkg::DONE_LEVEL);

        pidx_wide = (32'(phase_reg) * 32'(pblr_pkg::PULSE_STEPS)) >> 8;
        if (pidx_wide >= 32'(pblr_pkg::PULSE_STEPS))
            pidx = pblr_pkg::PULSE_IDX_W'(pblr_pkg::PULSE_STEPS - 1);
        else
            pidx = pidx_wide[pblr_pkg::PULSE_IDX_W-1:0];

        push_desc.done     = done;
        push_desc.color    = done ? finish_color : bar_color;
        push_desc.pulse_lv = pblr_pkg::PULSE_TABLE[pidx*8 +: 8];
        push_desc.head     = pos[pblr_pkg::LED_CNT_W+15:16];
        push_desc.frac     = pos[15:0];
        push_desc.last_idx = pblr_pkg::LED_IDX_W'(n_c - 7'd1);

        push = (state_reg == F_PUSH) && !q_stat.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            target_reg <= '0;
            shown_reg  <= '0;
            lvl_reg    <= '0;
            active_reg <= 1'b0;
            phase_reg  <= '0;
            up_reg     <= 1'b0;
            prod_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        lvl_reg    <= lvl_in;
                        active_reg <= s_tuser[1];
                        phase_reg  <= s_tdata[14:7];
                        if (s_tuser[0])
                        begin
                            // reseed: jump both levels, no frame
                            target_reg <= lvl_in;
                            shown_reg  <= lvl_in;
                        end
                        else
                            state_reg <= F_TARGET;
                    end
                end
                F_TARGET:
                begin
                    if (active_reg)
                        target_reg <= lvl_reg;
                    state_reg <= F_MUL;
                end
                F_MUL:
                begin
                    up_reg    <= (target_reg >= shown_reg);
                    prod_reg  <= alpha_c * diff;
                    state_reg <= F_APPLY;
                end
                F_APPLY:
                begin
                    shown_reg <= up_reg ? (shown_reg + step) : (shown_reg - step);
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!q_stat.full)
                        state_reg <= F_IDLE;
                end
                default:
                    state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

[src/pblr_queue.sv]
// Two-entry queue of frame descriptors between front and back end.
// Depends on pblr_pkg.
module pblr_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pblr_pkg::frame_desc_t  push_desc,
    input  logic                   pop,
    output pblr_pkg::frame_desc_t  pop_desc,
    output pblr_pkg::q_stat_t      q_stat
);

    pblr_pkg::frame_desc_t  mem_reg [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             count_reg;
    logic [1:0]             count_next;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign pop_desc     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_desc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

[src/pblr_back.sv]
// Back end: takes frame descriptors and emits one pixel item per LED through an
// output register. Depends on pblr_pkg.
module pblr_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pblr_pkg::q_stat_t      q_stat,
    input  pblr_pkg::frame_desc_t  pop_desc,
    output logic                   pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // pixel_index[5:0], red[13:6], green[21:14], blue[29:22]
    output logic                   m_tlast    // last_pixel
);

    pblr_pkg::frame_desc_t           desc_reg;
    logic                            busy_reg;
    logic [pblr_pkg::LED_IDX_W-1:0]  idx_reg;
    logic                            tvalid_reg;
    logic [31:0]                     tdata_reg;
    logic                            tlast_reg;

    logic                            out_free;
    logic [pblr_pkg::LED_CNT_W-1:0]  idx_ext;
    logic [pblr_pkg::LEVEL_W-1:0]    lv;
    logic [7:0]                      red;
    logic [7:0]                      green;
    logic [7:0]                      blue;

    // bar: (c * lv) >> 16; pulse: (c * lv) / 255 via reciprocal, exact for products of two 8-bit values
    function automatic logic [7:0] scale_ch(input logic [7:0] c,
                                            input logic [pblr_pkg::LEVEL_W-1:0] level,
                                            input logic pulse);
        logic [24:0] prod;
        logic [16:0] q;
        prod = c * level;
        q    = {1'b0, prod[15:0]} + 17'd1 + {9'd0, prod[15:8]};
        return pulse ? q[15:8] : prod[23:16];
    endfunction

    assign out_free = !tvalid_reg || m_tready;
    assign pop      = !busy_reg && !q_stat.empty;
    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;

    always_comb
    begin
        idx_ext = {1'b0, idx_reg};
        if (desc_reg.done)
            lv = {9'd0, desc_reg.pulse_lv};
        else
        begin
            if (idx_ext < desc_reg.head)
                lv = pblr_pkg::ONE_Q16;
            else if (idx_ext == desc_reg.head)
                lv = {1'b0, desc_reg.frac};
            else
                lv = '0;
            if (lv < pblr_pkg::FLOOR_LEVEL)
                lv = pblr_pkg::FLOOR_LEVEL;
        end
        red   = scale_ch(desc_reg.color[23:16], lv, desc_reg.done);
        green = scale_ch(desc_reg.color[15:8], lv, desc_reg.done);
        blue  = scale_ch(desc_reg.color[7:0], lv, desc_reg.done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_reg   <= '0;
            busy_reg   <= 1'b0;
            idx_reg    <= '0;
            tvalid_reg <= 1'b0;
            tdata_reg  <= '0;
            tlast_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                desc_reg <= pop_desc;
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            if (out_free)
            begin
                tvalid_reg <= busy_reg;
                if (busy_reg)
                begin
                    tdata_reg <= {2'b00, blue, green, red, idx_reg};
                    tlast_reg <= (idx_reg == desc_reg.last_idx);
                    if (idx_reg == desc_reg.last_idx)
                        busy_reg <= 1'b0;
                    else
                        idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

endmodule

[src/pblr_checker.sv]
// Port-level checks for the progress bar LED renderer, bound to the top level.
// Depends on progress_bar_led_renderer ports only.
module pblr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast
);

    // a stalled pixel holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel changed under stall");

    // pixels of a frame stream in index order
    a_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && $past(m_tvalid && m_tready && !m_tlast)
        |-> m_tdata[5:0] == $past(m_tdata[5:0]) + 6'd1)
        else $error("pixel index out of sequence");

    // a new frame starts at index zero
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && $past(m_tvalid && m_tready && m_tlast) |-> m_tdata[5:0] == 6'd0)
        else $error("frame does not start at pixel zero");

    // the highest LED is always the last of its frame
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5:0] == 6'd63 |-> m_tlast)
        else $error("pixel 63 not marked last");

endmodule

bind progress_bar_led_renderer pblr_checker u_pblr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
